// ===== design/lpgc_pkg.sv =====
// Shared types and constants for the laser point geometric correction block.
// Holds register indexes, reset values, datapath widths and pipeline control.
// No dependencies.
package lpgc_pkg;

    // Normalisation scale is 2**NORM_SHIFT (2048); datapath widths below assume it
    localparam int NORM_SHIFT = 11;
    localparam int XN_SHIFT   = NORM_SHIFT - 4;
    localparam int OUT_SHIFT  = 16 - NORM_SHIFT;

    localparam int COORD_W = 16;
    localparam int PROD_W  = 32;
    localparam int PSUM_W  = 34;
    localparam int PCL_W   = 30;
    // Normalised coordinate reaches +2**22 at the upper clamp
    localparam int XN_W    = 24;
    localparam int SQP_W   = 46;
    localparam int SQ_W    = 30;
    localparam int TRM_W   = 46;
    localparam int CUBP_W  = 53;
    localparam int CUB_W   = 37;
    localparam int SUM4_W  = 49;
    localparam int ACC_W   = 56;
    localparam int T_W     = 43;
    localparam int O_W     = 38;

    localparam int NSTG = 8;

    localparam logic [63:0] MATRIX_RST = 64'h1000_0000_0000_1000;
    localparam logic [8:0]  CMAP_RST   = 9'd273;

    typedef enum logic [2:0] {
        REG_MATRIX    = 3'd0,
        REG_OFFSETS   = 3'd1,
        REG_SHEAR_KS  = 3'd2,
        REG_LIN_BOW   = 3'd3,
        REG_PINCUSH   = 3'd4,
        REG_COLOR_MAP = 3'd5,
        REG_TTL       = 3'd6
    } reg_idx_t;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic [NSTG-1:0] en;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [63:0] matrix;
        logic [31:0] offsets;
        logic [63:0] shear_ks;
        logic [63:0] lin_bow;
        logic [31:0] pincush;
    } geo_cfg_t;

endpackage

// ===== design/lpgc_geo.sv =====
// Coordinate pipeline: matrix, offset, clamp, normalise, polynomial terms,
// rounding and saturation over eight register stages. Depends on lpgc_pkg.
module lpgc_geo (
    input  logic                          aclk,
    input  lpgc_pkg::pipe_ctrl_t          ctrl,
    input  lpgc_pkg::geo_cfg_t            cfg,
    input  logic signed [15:0]            in_x,
    input  logic signed [15:0]            in_y,
    output logic signed [15:0]            out_x,
    output logic signed [15:0]            out_y
);
    import lpgc_pkg::*;

    logic signed [COORD_W-1:0] m00, m01, m10, m11, offx, offy;
    logic signed [COORD_W-1:0] shx, shy, ksx, ksy, lnx, lny, bwx, bwy, pcx, pcy;

    assign m00  = cfg.matrix[15:0];
    assign m01  = cfg.matrix[31:16];
    assign m10  = cfg.matrix[47:32];
    assign m11  = cfg.matrix[63:48];
    assign offx = cfg.offsets[15:0];
    assign offy = cfg.offsets[31:16];
    assign shx  = cfg.shear_ks[15:0];
    assign shy  = cfg.shear_ks[31:16];
    assign ksx  = cfg.shear_ks[47:32];
    assign ksy  = cfg.shear_ks[63:48];
    assign lnx  = cfg.lin_bow[15:0];
    assign lny  = cfg.lin_bow[31:16];
    assign bwx  = cfg.lin_bow[47:32];
    assign bwy  = cfg.lin_bow[63:48];
    assign pcx  = cfg.pincush[15:0];
    assign pcy  = cfg.pincush[31:16];

    // Stage 0: matrix products
    logic signed [PROD_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            p00_reg <= m00 * in_x;
            p01_reg <= m01 * in_y;
            p10_reg <= m10 * in_x;
            p11_reg <= m11 * in_y;
        end
    end

    // Stage 1: offset, clamp and normalise
    logic signed [PSUM_W-1:0] psx, psy;
    logic signed [PCL_W-1:0]  pcx_c, pcy_c;
    logic signed [PCL_W:0]    pbx, pby;
    logic signed [XN_W-1:0]   xn1_reg, yn1_reg;
    localparam logic signed [PSUM_W-1:0] CL_HI = PSUM_W'(64'sd536870911);
    localparam logic signed [PSUM_W-1:0] CL_LO = -PSUM_W'(64'sd536870912);

    always_comb begin
        psx = PSUM_W'(p00_reg) + PSUM_W'(p01_reg) + (PSUM_W'(offx) <<< 12);
        psy = PSUM_W'(p10_reg) + PSUM_W'(p11_reg) + (PSUM_W'(offy) <<< 12);
        pcx_c = (psx > CL_HI) ? CL_HI[PCL_W-1:0] :
                (psx < CL_LO) ? CL_LO[PCL_W-1:0] : psx[PCL_W-1:0];
        pcy_c = (psy > CL_HI) ? CL_HI[PCL_W-1:0] :
                (psy < CL_LO) ? CL_LO[PCL_W-1:0] : psy[PCL_W-1:0];
        pbx = (PCL_W+1)'(pcx_c) + (PCL_W+1)'(1 << (NORM_SHIFT - 5));
        pby = (PCL_W+1)'(pcy_c) + (PCL_W+1)'(1 << (NORM_SHIFT - 5));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[1]) begin
            xn1_reg <= XN_W'(pbx >>> XN_SHIFT);
            yn1_reg <= XN_W'(pby >>> XN_SHIFT);
        end
    end

    // Stage 2: square and cross products
    logic signed [SQP_W-1:0] mxx_reg, myy_reg, mxy_reg;
    logic signed [XN_W-1:0]  xn2_reg, yn2_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.en[2]) begin
            mxx_reg <= xn1_reg * xn1_reg;
            myy_reg <= yn1_reg * yn1_reg;
            mxy_reg <= xn1_reg * yn1_reg;
            xn2_reg <= xn1_reg;
            yn2_reg <= yn1_reg;
        end
    end

    // Stage 3: round the second-order terms
    logic signed [SQP_W:0] rxx, ryy, rxy;
    logic signed [SQ_W-1:0] xx3_reg, yy3_reg, xy3_reg;
    logic signed [XN_W-1:0] xn3_reg, yn3_reg;
    always_comb begin
        rxx = ((SQP_W+1)'(mxx_reg) + (SQP_W+1)'(32768)) >>> 16;
        ryy = ((SQP_W+1)'(myy_reg) + (SQP_W+1)'(32768)) >>> 16;
        rxy = ((SQP_W+1)'(mxy_reg) + (SQP_W+1)'(32768)) >>> 16;
    end
    always_ff @(posedge aclk) begin
        if (ctrl.en[3]) begin
            xx3_reg <= rxx[SQ_W-1:0];
            yy3_reg <= ryy[SQ_W-1:0];
            xy3_reg <= rxy[SQ_W-1:0];
            xn3_reg <= xn2_reg;
            yn3_reg <= yn2_reg;
        end
    end

    // Stage 4: cubic products and coefficient products
    logic signed [CUBP_W-1:0] mxyy_reg, mxxy_reg;
    logic signed [TRM_W-1:0]  tx_sh_reg, tx_ks_reg, tx_ln_reg, tx_bw_reg;
    logic signed [TRM_W-1:0]  ty_sh_reg, ty_ks_reg, ty_ln_reg, ty_bw_reg;
    logic signed [XN_W-1:0]   xn4_reg, yn4_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.en[4]) begin
            mxyy_reg  <= yy3_reg * xn3_reg;
            mxxy_reg  <= xx3_reg * yn3_reg;
            tx_sh_reg <= TRM_W'(shx * yn3_reg);
            tx_ks_reg <= ksx * xy3_reg;
            tx_ln_reg <= lnx * xx3_reg;
            tx_bw_reg <= bwx * yy3_reg;
            ty_sh_reg <= TRM_W'(shy * xn3_reg);
            ty_ks_reg <= ksy * xy3_reg;
            ty_ln_reg <= lny * yy3_reg;
            ty_bw_reg <= bwy * xx3_reg;
            xn4_reg   <= xn3_reg;
            yn4_reg   <= yn3_reg;
        end
    end

    // Stage 5: round cubic terms, sum the four coefficient terms
    logic signed [CUBP_W:0]  rxyy, rxxy;
    logic signed [CUB_W-1:0] xyy5_reg, xxy5_reg;
    logic signed [SUM4_W-1:0] sx5_reg, sy5_reg;
    logic signed [XN_W-1:0]  xn5_reg, yn5_reg;
    always_comb begin
        rxyy = ((CUBP_W+1)'(mxyy_reg) + (CUBP_W+1)'(32768)) >>> 16;
        rxxy = ((CUBP_W+1)'(mxxy_reg) + (CUBP_W+1)'(32768)) >>> 16;
    end
    always_ff @(posedge aclk) begin
        if (ctrl.en[5]) begin
            xyy5_reg <= rxyy[CUB_W-1:0];
            xxy5_reg <= rxxy[CUB_W-1:0];
            sx5_reg  <= SUM4_W'(tx_sh_reg) + SUM4_W'(tx_ks_reg)
                      + SUM4_W'(tx_ln_reg) + SUM4_W'(tx_bw_reg);
            sy5_reg  <= SUM4_W'(ty_sh_reg) + SUM4_W'(ty_ks_reg)
                      + SUM4_W'(ty_ln_reg) + SUM4_W'(ty_bw_reg);
            xn5_reg  <= xn4_reg;
            yn5_reg  <= yn4_reg;
        end
    end

    // Stage 6: pincushion product, fold in the base coordinate
    logic signed [CUBP_W-1:0] pcpx_reg, pcpy_reg;
    logic signed [ACC_W-1:0]  basex_reg, basey_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.en[6]) begin
            pcpx_reg  <= CUBP_W'(pcx * xyy5_reg);
            pcpy_reg  <= CUBP_W'(pcy * xxy5_reg);
            basex_reg <= ACC_W'(sx5_reg) + (ACC_W'(xn5_reg) <<< 13);
            basey_reg <= ACC_W'(sy5_reg) + (ACC_W'(yn5_reg) <<< 13);
        end
    end

    // Stage 7: accumulate, round twice, saturate
    logic signed [ACC_W-1:0] accx, accy;
    logic signed [T_W-1:0]   tx, ty;
    logic signed [T_W:0]     tbx, tby;
    logic signed [O_W-1:0]   ox, oy;
    logic signed [15:0]      sx, sy;
    logic signed [15:0]      outx_reg, outy_reg;
    localparam logic signed [O_W-1:0] O_HI = O_W'(32767);
    localparam logic signed [O_W-1:0] O_LO = -O_W'(32768);

    always_comb begin
        accx = basex_reg + ACC_W'(pcpx_reg) + ACC_W'(4096);
        accy = basey_reg + ACC_W'(pcpy_reg) + ACC_W'(4096);
        tx   = T_W'(accx >>> 13);
        ty   = T_W'(accy >>> 13);
        tbx  = (T_W+1)'(tx) + (T_W+1)'(1 << (OUT_SHIFT - 1));
        tby  = (T_W+1)'(ty) + (T_W+1)'(1 << (OUT_SHIFT - 1));
        ox   = O_W'(tbx >>> OUT_SHIFT);
        oy   = O_W'(tby >>> OUT_SHIFT);
        sx   = (ox > O_HI) ? 16'sh7fff : (ox < O_LO) ? 16'sh8000 : ox[15:0];
        sy   = (oy > O_HI) ? 16'sh7fff : (oy < O_LO) ? 16'sh8000 : oy[15:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[7]) begin
            outx_reg <= sx;
            outy_reg <= sy;
        end
    end

    assign out_x = outx_reg;
    assign out_y = outy_reg;

endmodule

// ===== design/laser_point_geometric_correction.sv =====
// Each input item passes through eight register stages to become a result item.
// Throughput: one item per cycle unless m_tready stalls; each stage advances when empty
// or when the next moves, so bubbles close up while the output register waits.
// Reset: aresetn synchronous, active low; clears valid bits and loads the
// configuration registers with their reset values (identity matrix and colour map).
// Depends on lpgc_pkg and lpgc_geo.
module laser_point_geometric_correction (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // in_x, in_y, in_red, in_green, in_blue
    input  logic        s_tlast,   // in_frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_x, out_y, out_red, out_green, out_blue
    output logic        m_tlast,   // out_frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import lpgc_pkg::*;

    // Configuration registers
    logic [63:0] matrix_reg, shear_ks_reg, lin_bow_reg;
    logic [31:0] offsets_reg, pincush_reg;
    logic [8:0]  cmap_reg;
    logic [7:0]  ttl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_reg   <= MATRIX_RST;
            offsets_reg  <= '0;
            shear_ks_reg <= '0;
            lin_bow_reg  <= '0;
            pincush_reg  <= '0;
            cmap_reg     <= CMAP_RST;
            ttl_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MATRIX:    matrix_reg   <= cfg_data;
                REG_OFFSETS:   offsets_reg  <= cfg_data[31:0];
                REG_SHEAR_KS:  shear_ks_reg <= cfg_data;
                REG_LIN_BOW:   lin_bow_reg  <= cfg_data;
                REG_PINCUSH:   pincush_reg  <= cfg_data[31:0];
                REG_COLOR_MAP: cmap_reg     <= cfg_data[8:0];
                REG_TTL:       ttl_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Stage enables: load when empty or when the next stage moves on
    logic [NSTG-1:0] vld_reg;
    pipe_ctrl_t      ctrl;

    always_comb begin
        ctrl.en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            ctrl.en[i] = !vld_reg[i] || ctrl.en[i+1];
        end
    end

    assign s_tready = ctrl.en[0];

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ctrl.en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (ctrl.en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Colour remap with wrap, then optional threshold
    logic [7:0] in_r, in_g, in_b;
    logic [7:0] sum_c [3];
    logic [7:0] col_c [3];

    assign in_r = s_tdata[39:32];
    assign in_g = s_tdata[47:40];
    assign in_b = s_tdata[55:48];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_c[k] = (cmap_reg[k]   ? in_r : 8'd0)
                     + (cmap_reg[3+k] ? in_g : 8'd0)
                     + (cmap_reg[6+k] ? in_b : 8'd0);
            if (ttl_reg != 8'd0) begin
                col_c[k] = (sum_c[k] >= ttl_reg) ? 8'hff : 8'h00;
            end else begin
                col_c[k] = sum_c[k];
            end
        end
    end

    // Carry colours and frame end alongside the coordinate stages
    logic [24:0] side_reg [NSTG];

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            side_reg[0] <= {s_tlast, col_c[2], col_c[1], col_c[0]};
        end
        for (int i = 1; i < NSTG; i++) begin
            if (ctrl.en[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Coordinate pipeline
    geo_cfg_t           gcfg;
    logic signed [15:0] ox, oy;

    assign gcfg.matrix   = matrix_reg;
    assign gcfg.offsets  = offsets_reg;
    assign gcfg.shear_ks = shear_ks_reg;
    assign gcfg.lin_bow  = lin_bow_reg;
    assign gcfg.pincush  = pincush_reg;

    lpgc_geo u_geo (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .cfg   (gcfg),
        .in_x  (s_tdata[15:0]),
        .in_y  (s_tdata[31:16]),
        .out_x (ox),
        .out_y (oy)
    );

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {side_reg[NSTG-1][23:0], oy, ox};
    assign m_tlast  = side_reg[NSTG-1][24];

endmodule

// ===== design/lpgc_checker.sv =====
// Port-level checks for the laser point geometric correction block, bound to the top.
// Depends on the top-level port list only.
module lpgc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_ready
);
    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // An empty output stage never blocks the input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Nothing comes out straight after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // Configuration is always taken
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind laser_point_geometric_correction lpgc_checker u_lpgc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

// ===== sim/tb.sv =====
// Testbench for laser_point_geometric_correction: directed table then random points.
// Predicts corrected points in fixed point and checks each one field by field.
// Depends on lpgc_pkg and the block's RTL.
module tb;
    import lpgc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RAND_PER_PHASE = 665;
    localparam int CFG_EVERY      = 133;

    typedef struct packed {
        logic        last;
        logic [7:0]  b;
        logic [7:0]  g;
        logic [7:0]  r;
        logic [15:0] y;
        logic [15:0] x;
    } point_t;

    typedef struct {
        point_t pt;
        logic   has_exp;
        point_t exp_pt;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // Shadow copy of the configuration registers
    logic [63:0] sh_matrix;
    logic [31:0] sh_offsets;
    logic [63:0] sh_shear_ks;
    logic [63:0] sh_lin_bow;
    logic [31:0] sh_pincush;
    logic [8:0]  sh_cmap;
    logic [7:0]  sh_ttl;

    point_t    pending_points[$];
    stim_row_t dir_rows[$];
    int        n_fail = 0;
    int        n_out = 0;
    int        n_sent;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;

    laser_point_geometric_correction dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint sl16(logic [63:0] v, int idx);
        return longint'($signed(v[16*idx +: 16]));
    endfunction

    // Add half, then floor by 2^s: round half up
    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [15:0] axis_out(longint a, longint b, longint aa, longint bb,
                                             longint ab, longint cub, int ax);
        longint acc;
        longint t;
        longint o;
        acc = a * 8192 + sl16(sh_shear_ks, ax) * b + sl16(sh_shear_ks, 2 + ax) * ab
            + sl16(sh_lin_bow, ax) * aa + sl16(sh_lin_bow, 2 + ax) * bb
            + sl16({32'd0, sh_pincush}, ax) * cub;
        t = rnd_shift(acc, 13);
        o = sat(rnd_shift(t * 2048, 16), -32768, 32767);
        return o[15:0];
    endfunction

    function automatic logic [7:0] mix_colour(int k, logic [7:0] r, logic [7:0] g,
                                              logic [7:0] b);
        logic [7:0] s;
        s = 8'd0;
        if (sh_cmap[k]) s = s + r;
        if (sh_cmap[3 + k]) s = s + g;
        if (sh_cmap[6 + k]) s = s + b;
        if (sh_ttl != 8'd0) s = (s >= sh_ttl) ? 8'd255 : 8'd0;
        return s;
    endfunction

    function automatic point_t corrected_point(point_t p);
        point_t o;
        longint x, y, px, py, xn, yn, xx, yy, xy;
        x  = longint'($signed(p.x));
        y  = longint'($signed(p.y));
        px = sl16(sh_matrix, 0) * x + sl16(sh_matrix, 1) * y + sl16(sh_offsets, 0) * 4096;
        py = sl16(sh_matrix, 2) * x + sl16(sh_matrix, 3) * y + sl16(sh_offsets, 1) * 4096;
        px = sat(px, -536870912, 536870911);
        py = sat(py, -536870912, 536870911);
        // Arithmetic shift of (p*32 + 2048) by 12 is the floored division
        xn = (px * 32 + 2048) >>> 12;
        yn = (py * 32 + 2048) >>> 12;
        xx = rnd_shift(xn * xn, 16);
        yy = rnd_shift(yn * yn, 16);
        xy = rnd_shift(xn * yn, 16);
        o.x    = axis_out(xn, yn, xx, yy, xy, rnd_shift(yy * xn, 16), 0);
        o.y    = axis_out(yn, xn, yy, xx, xy, rnd_shift(xx * yn, 16), 1);
        o.r    = mix_colour(0, p.r, p.g, p.b);
        o.g    = mix_colour(1, p.r, p.g, p.b);
        o.b    = mix_colour(2, p.r, p.g, p.b);
        o.last = p.last;
        return o;
    endfunction

    // Write one register while the block is idle
    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MATRIX:    sh_matrix   = val;
            REG_OFFSETS:   sh_offsets  = val[31:0];
            REG_SHEAR_KS:  sh_shear_ks = val;
            REG_LIN_BOW:   sh_lin_bow  = val;
            REG_PINCUSH:   sh_pincush  = val[31:0];
            REG_COLOR_MAP: sh_cmap     = val[8:0];
            REG_TTL:       sh_ttl      = val[7:0];
            default: ;
        endcase
    endtask

    // Hold off until every expected point has come out, then let the pipe settle
    task automatic wait_drained();
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (NSTG + 4) @(posedge aclk);
    endtask

    // Offer one item and queue the point expected back for it
    task automatic send_point(point_t p, point_t e);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p[55:0];
        s_tlast  <= p.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_points = {pending_points, e};
        n_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic point_t rand_point();
        point_t p;
        int sel;
        p = point_t'(57'({$urandom, $urandom}));
        sel = $urandom_range(7);
        if (sel == 0) p.x = 16'h8000;
        if (sel == 1) p.y = 16'h7fff;
        if (sel == 2) begin
            p.x = 16'($urandom_range(4095)) - 16'd2048;
            p.y = 16'($urandom_range(4095)) - 16'd2048;
        end
        return p;
    endfunction

    function automatic point_t mk(int x, int y, int r, int g, int b, bit l);
        point_t p;
        p.x = 16'(x); p.y = 16'(y); p.r = 8'(r); p.g = 8'(g); p.b = 8'(b); p.last = l;
        return p;
    endfunction

    function automatic stim_row_t row(point_t p, bit he, point_t e);
        stim_row_t s;
        s.pt = p; s.has_exp = he; s.exp_pt = e;
        return s;
    endfunction

    // Random registers: wide slices biased toward small polynomial terms
    function automatic logic [63:0] rand_coeffs(int scale);
        logic [63:0] v;
        for (int i = 0; i < 4; i++)
            v[16*i +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($signed(16'($urandom)) >>> scale);
        return v;
    endfunction

    task automatic random_config();
        write_reg(REG_MATRIX, rand_coeffs(1));
        write_reg(REG_OFFSETS, {$urandom} & 64'hffff_ffff);
        write_reg(REG_SHEAR_KS, rand_coeffs(3));
        write_reg(REG_LIN_BOW, rand_coeffs(3));
        write_reg(REG_PINCUSH, rand_coeffs(3) & 64'hffff_ffff);
        write_reg(REG_COLOR_MAP, 64'($urandom_range(511)));
        write_reg(REG_TTL, ($urandom_range(1) == 0) ? 64'd0 : 64'($urandom_range(255)));
    endtask

    // Walk the directed table; rows without a typed result use the predictor
    task automatic run_table();
        foreach (dir_rows[i]) begin
            send_point(dir_rows[i].pt, dir_rows[i].has_exp ? dir_rows[i].exp_pt
                                                           : corrected_point(dir_rows[i].pt));
        end
        stop_sending();
        wait_drained();
    endtask

    // Output side: stall at random and check each point against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                point_t got;
                point_t want;
                got = point_t'({m_tlast, m_tdata});
                n_out++;
                if (pending_points.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) $display("unexpected point %h", got);
                end else begin
                    want = pending_points.pop_front();
                    if (got !== want) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("point %0d: x %h/%h y %h/%h rgb %h%h%h/%h%h%h last %b/%b",
                                     n_out, want.x, got.x, want.y, got.y, want.r, want.g,
                                     want.b, got.r, got.g, got.b, want.last, got.last);
                    end
                end
            end
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d points outstanding",
                         pending_points.size());
                $display("laser_point_geometric_correction regression: fail");
                $finish;
            end
        end
    end

    initial begin
        point_t rp;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        cfg_valid = 1'b0; cfg_index = REG_MATRIX; cfg_data = '0;
        n_sent = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        sh_matrix = MATRIX_RST; sh_offsets = '0; sh_shear_ks = '0; sh_lin_bow = '0;
        sh_pincush = '0; sh_cmap = CMAP_RST; sh_ttl = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table after reset: identity path, extremes pass straight through
        dir_rows = {dir_rows, row(mk(0, 0, 0, 0, 0, 0), 1, mk(0, 0, 0, 0, 0, 0))};
        dir_rows = {dir_rows, row(mk(32767, -32768, 255, 255, 255, 1), 1,
                                  mk(32767, -32768, 255, 255, 255, 1))};
        dir_rows = {dir_rows, row(mk(-32768, 32767, 1, 128, 254, 0), 1,
                                  mk(-32768, 32767, 1, 128, 254, 0))};
        dir_rows = {dir_rows, row(mk(1234, -567, 12, 34, 56, 1), 1,
                                  mk(1234, -567, 12, 34, 56, 1))};
        run_table();

        // Doubled scale saturates the extremes; threshold of 100 switches colours
        write_reg(REG_MATRIX, 64'h2000_0000_0000_2000);
        write_reg(REG_TTL, 64'd100);
        dir_rows = {};
        dir_rows = {dir_rows, row(mk(32767, -32768, 255, 99, 100, 1), 1,
                                  mk(32767, -32768, 255, 0, 255, 1))};
        dir_rows = {dir_rows, row(mk(100, -100, 7, 200, 150, 0), 0, '0)};
        dir_rows = {dir_rows, row(mk(-20000, 16000, 101, 0, 99, 1), 0, '0)};
        run_table();

        // Random points: sender idles little, then receiver, then neither
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 86 : 0;
            recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 14 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % CFG_EVERY == 0) begin
                    stop_sending();
                    wait_drained();
                    random_config();
                end
                rp = rand_point();
                send_point(rp, corrected_point(rp));
            end
        end
        stop_sending();
        wait_drained();

        $display("covered identity and threshold rows, then %0d points in all", n_sent);
        $display("under three stall patterns with the registers rewritten between bursts");
        if (n_fail == 0 && n_out == n_sent && pending_points.size() == 0)
            $display("laser_point_geometric_correction regression: pass");
        else
            $display("laser_point_geometric_correction regression: fail");
        $finish;
    end
endmodule
